### rtl/core/zero_one_knapsack_max_value_unit_assert.svh
// Assertion macros for the knapsack unit's RTL files; included by the controller.
// Each macro expects signals named clk and rst in the including module.
`ifndef ZERO_ONE_KNAPSACK_MAX_VALUE_UNIT_ASSERT_SVH
`define ZERO_ONE_KNAPSACK_MAX_VALUE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KMV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/kmv_pkg.sv
// Shared types and constants for the knapsack maximum-value unit.
// No dependencies; imported by the controller, datapath and top level.
package kmv_pkg;

  // Fixed field widths.
  localparam int CAP_W  = 10;
  localparam int VOL_W  = 8;
  localparam int VAL_W  = 8;
  localparam int BEST_W = 18;

  // Defaults for the top-level parameters.
  localparam int TABLE_DEPTH_DEFAULT = 1024;
  localparam int VALUE_WIDTH_DEFAULT = 18;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the input beat and preset the sweep counter
    logic step;         // issue one table read and move the counter down
    logic sweep_end;    // last write of the sweep is going out this cycle
    logic answer_rd;    // read the table entry at the configured capacity
    logic answer_load;  // move the answer into the output register
  } kmv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;     // sweep counter is at entry zero
    logic last;         // the held item closes a problem
    logic out_free;     // output register can take a new result
  } kmv_status_t;

endpackage

### rtl/core/kmv_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
module kmv_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered reads; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/core/kmv_ctrl.sv
// Controller state machine for the knapsack unit: sequences load, sweep and answer.
// Depends on kmv_pkg and the assertion macro header.
`include "zero_one_knapsack_max_value_unit_assert.svh"

module kmv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kmv_pkg::kmv_status_t status,
  output kmv_pkg::kmv_cmd_t    cmd
);
  import kmv_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SWEEP  = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_ANSWER = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next-state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.step = 1'b1;
        if (status.cnt_zero) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.sweep_end = 1'b1;
        state_next    = status.last ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd.answer_rd = 1'b1;
        state_next    = S_ANSWER;
      end
      S_ANSWER: begin
        // Keep the read address steady until the output register is free.
        cmd.answer_rd = 1'b1;
        if (status.out_free) begin
          cmd.answer_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted beat starts a sweep, and the sweep ends only through the drain cycle.
  `KMV_ASSERT_NEXT(a_accept_sweeps, in_valid && in_ready, state == S_SWEEP, "accept did not start sweep")
  `KMV_ASSERT_NEXT(a_sweep_drains, state == S_SWEEP && status.cnt_zero, state == S_DRAIN, "sweep did not drain")
  // Only a closing item leads to an answer read.
  `KMV_ASSERT_NEXT(a_drain_idle, state == S_DRAIN && !status.last, state == S_IDLE, "answer without last item")
  // The answer never overwrites a result that is still waiting.
  `KMV_ASSERT_SAME(a_answer_free, cmd.answer_load, status.out_free, "answer overwrote pending result")

endmodule

### rtl/core/kmv_datapath.sv
// Datapath for the knapsack unit: item and capacity registers, sweep counter,
// two-stage table read-modify-write, output register. Depends on kmv_pkg, kmv_ram.
module kmv_datapath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 18
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [kmv_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic [kmv_pkg::VOL_W-1:0] item_volume,
  input  logic [kmv_pkg::VAL_W-1:0] item_value,
  input  logic                      last_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [kmv_pkg::BEST_W-1:0] best_value,
  input  kmv_pkg::kmv_cmd_t         cmd,
  output kmv_pkg::kmv_status_t      status
);
  import kmv_pkg::*;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CMP_W   = (ADDR_W > VOL_W) ? ADDR_W : VOL_W;
  localparam int CAPIX_W = (ADDR_W > CAP_W) ? ADDR_W : CAP_W;

  // Configuration and held item.
  logic [CAP_W-1:0] capacity;
  logic [VOL_W-1:0] vol;
  logic [VAL_W-1:0] val;
  logic             last;
  // Set while the table holds nothing of the current problem; reads count as zero.
  logic             blank;

  // Sweep counter and stage-one registers.
  logic [ADDR_W-1:0] cnt;
  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_take;
  logic              s1_zero;

  // Table ports.
  logic [ADDR_W-1:0]      rd_addr_a;
  logic [ADDR_W-1:0]      rd_addr_b;
  logic [VALUE_WIDTH-1:0] rd_data_a;
  logic [VALUE_WIDTH-1:0] rd_data_b;
  logic [VALUE_WIDTH-1:0] wr_data;

  // Stage-zero and stage-one combinational values.
  logic [CMP_W-1:0]       j_ext;
  logic [CMP_W-1:0]       vol_ext;
  logic                   fits;
  logic [CMP_W-1:0]       diff;
  logic [CAPIX_W-1:0]     cap_ext;
  logic [CAPIX_W-1:0]     cap_lim;
  logic [ADDR_W-1:0]      cap_idx;
  logic [VALUE_WIDTH-1:0] old_val;
  logic [VALUE_WIDTH-1:0] base_val;
  logic [VALUE_WIDTH:0]   sum;
  logic [VALUE_WIDTH-1:0] cand;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vol  <= item_volume;
      val  <= item_value;
      last <= last_item;
    end
  end

  // The table counts as blank after reset and after each closing item.
  always_ff @(posedge clk) begin
    if (rst) begin
      blank <= 1'b1;
    end else if (cmd.sweep_end) begin
      blank <= last;
    end
  end

  // Sweep counter runs from the top entry down to entry zero.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt <= ADDR_W'(TABLE_DEPTH - 1);
    end else if (cmd.step) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Stage zero: address generation.
  always_comb begin
    j_ext   = CMP_W'(cnt);
    vol_ext = CMP_W'(vol);
    fits    = (j_ext >= vol_ext);
    diff    = j_ext - vol_ext;
    cap_ext = CAPIX_W'(capacity);
    cap_lim = CAPIX_W'(TABLE_DEPTH - 1);
    cap_idx = (cap_ext > cap_lim) ? ADDR_W'(cap_lim) : ADDR_W'(cap_ext);
    rd_addr_a = cmd.answer_rd ? cap_idx : ADDR_W'(diff);
    rd_addr_b = cnt;
  end

  // Stage-one control is registered in step with the registered table read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= cnt;
    s1_take <= fits && (cnt != '0);
    s1_zero <= (cnt == '0);
  end

  // Stage one: saturating add and keep the larger value. Entry zero is written as zero.
  always_comb begin
    old_val  = blank ? '0 : rd_data_b;
    base_val = blank ? '0 : rd_data_a;
    sum      = {1'b0, base_val} + (VALUE_WIDTH + 1)'(val);
    cand     = sum[VALUE_WIDTH] ? '1 : sum[VALUE_WIDTH-1:0];
    if (s1_zero) begin
      wr_data = '0;
    end else if (s1_take && (cand > old_val)) begin
      wr_data = cand;
    end else begin
      wr_data = old_val;
    end
  end

  kmv_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (s1_valid),
    .waddr   (s1_addr),
    .wdata   (wr_data),
    .raddr_a (rd_addr_a),
    .rdata_a (rd_data_a),
    .raddr_b (rd_addr_b),
    .rdata_b (rd_data_b)
  );

  // Output register: holds a result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.answer_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.answer_load) begin
      best_value <= BEST_W'(rd_data_a);
    end
  end

  // Status back to the controller.
  always_comb begin
    status.cnt_zero = (cnt == '0);
    status.last     = last;
    status.out_free = !out_valid || out_ready;
  end

endmodule

### rtl/core/zero_one_knapsack_max_value_unit.sv
// Channel  | Direction | Signals
// ---------+-----------+----------------------------------------------------
// cfg      | in        | cfg_wr_en, cfg_wr_data (capacity)
// in       | in        | in_valid/in_ready; item_volume, item_value, last_item
// out      | out       | out_valid/out_ready; best_value
//
// An item is one table read-modify-write per entry through the two-read,
// one-write table memory, framed by the accept in the idle state and the drain state.
// A closing item then reads the answer entry in the read and answer states.
// Reset marks the table blank; the first sweep of a problem writes every entry,
// so no clearing pass is needed after reset or between problems.
// A result waits in the output register while the next item is taken; a later
// result waits until that register is free.
//
// Top level of the knapsack maximum-value unit: controller plus datapath.
// Depends on kmv_pkg, kmv_ctrl, kmv_datapath and kmv_ram.
module zero_one_knapsack_max_value_unit #(
  parameter int TABLE_DEPTH = kmv_pkg::TABLE_DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = kmv_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [kmv_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [kmv_pkg::VOL_W-1:0]  item_volume,
  input  logic [kmv_pkg::VAL_W-1:0]  item_value,
  input  logic                       last_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kmv_pkg::BEST_W-1:0] best_value
);
  import kmv_pkg::*;

  kmv_cmd_t    cmd;
  kmv_status_t status;

  kmv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kmv_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_volume (item_volume),
    .item_value  (item_value),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .best_value  (best_value),
    .cmd         (cmd),
    .status      (status)
  );

endmodule
